FILE: sv/prbs_chk_pkg.sv
package prbs_chk_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LFSR_W  = 15;
	localparam int unsigned POS_W   = 16;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned CFG_W   = 15;
	localparam int unsigned IDX_W   = 1;

	localparam int unsigned DEF_MAX_RUN_LENGTH = 65536;
	localparam int unsigned COUNT_FIELD_MAX    = 131071;

	// Pattern modes; codes above PRBS behave as PRBS.
	localparam logic [MODE_W-1:0] MODE_ZEROS = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ONES  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_55    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_AA    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PRBS  = 3'd4;

	localparam logic [BYTE_W-1:0] FILL_ZEROS = 8'h00;
	localparam logic [BYTE_W-1:0] FILL_ONES  = 8'hFF;
	localparam logic [BYTE_W-1:0] FILL_55    = 8'h55;
	localparam logic [BYTE_W-1:0] FILL_AA    = 8'hAA;

	localparam logic [LFSR_W-1:0] SEED_LSB   = 15'h0001;
	localparam logic [LFSR_W-1:0] SEED_RESET = 15'h0001;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_PATTERN_MODE = 1'b0;
	localparam logic [IDX_W-1:0] REG_PRBS_SEED    = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] received_byte;
		logic              last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  expected_byte;
		logic               mismatch;
		logic [COUNT_W-1:0] error_total;
		logic [POS_W-1:0]   first_error_offset;
		logic               first_error_valid;
		logic               run_complete;
	} result_item_t;

	// Control from the pipeline into the run statistics.
	typedef struct packed {
		logic advance;
		logic mismatch;
		logic last_byte;
	} stats_ctl_t;

	// Run statistics as they stand after the byte being retired.
	typedef struct packed {
		logic               run_start;
		logic [COUNT_W-1:0] error_total;
		logic [POS_W-1:0]   first_error_offset;
		logic               first_error_valid;
	} stats_t;

endpackage

FILE: sv/prbs_pattern_checker.sv
// Link-test pattern checker. Each byte transfer on the byte channel carries one byte
// received back over the link; the block generates the byte it expected at that position
// (a fixed fill of 0x00, 0xFF, 0x55 or 0xAA, or a PRBS byte from a 15-bit LFSR with
// feedback s[14]^s[13]^s[12]^s[10], eight shifts per byte, LSB first) and returns one
// result transfer per byte with the expected byte, a mismatch flag, the saturating
// mismatch count of the current run and the offset of the first mismatch. The LFSR is
// loaded with prbs_seed with bit 0 forced to one at the start of every run, so a new seed
// takes effect at the next run. A byte with last_byte set closes the run and the next
// byte starts a fresh one. The block takes one byte per clock cycle while its results are
// taken; a byte is held in the input register, and its result is registered in the result
// register before it is offered. A stalled result holds the byte in the input register, and
// further bytes are stalled until it moves on. Configuration writes are to be made while
// no byte is in flight.
module prbs_pattern_checker
	import prbs_chk_pkg::*;
#(
	parameter int unsigned MAX_RUN_LENGTH = DEF_MAX_RUN_LENGTH
) (
	input  logic             clk,
	input  logic             arst_n,

	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,

	input  logic             byte_valid,
	output logic             byte_stall,
	input  byte_item_t       byte_item,

	output logic             result_valid,
	input  logic             result_stall,
	output result_item_t     result_item
);

	// Configuration registers.
	logic [MODE_W-1:0] mode_q;
	logic [CFG_W-1:0]  seed_q;

	// Input register and result register.
	byte_item_t   item_s1;
	logic         valid_s1;
	result_item_t result_s2;
	logic         valid_s2;

	logic              s2_free;
	logic              advance;
	logic              byte_accept;
	logic [BYTE_W-1:0] expected;
	logic              miss;
	stats_ctl_t        ctl;
	stats_t            stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PRBS;
			seed_q <= SEED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_MODE: mode_q <= cfg_data[MODE_W-1:0];
				REG_PRBS_SEED:    seed_q <= cfg_data;
			endcase
		end
	end

	// The result register empties when its transfer completes, so the byte held in the
	// input register moves on in the same cycle.
	assign s2_free     = !valid_s2 || !result_stall;
	assign advance     = valid_s1 && s2_free;
	assign byte_stall  = valid_s1 && !s2_free;
	assign byte_accept = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_accept) begin
			item_s1 <= byte_item;
		end
	end

	prbs_chk_gen u_gen (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.run_start     (stat.run_start),
		.mode          (mode_q),
		.seed          (seed_q),
		.expected_byte (expected)
	);

	assign miss = (item_s1.received_byte != expected);

	assign ctl.advance   = advance;
	assign ctl.mismatch  = miss;
	assign ctl.last_byte = item_s1.last_byte;

	prbs_chk_stats #(
		.MAX_RUN_LENGTH (MAX_RUN_LENGTH)
	) u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.expected_byte      <= expected;
			result_s2.mismatch           <= miss;
			result_s2.error_total        <= stat.error_total;
			result_s2.first_error_offset <= stat.first_error_offset;
			result_s2.first_error_valid  <= stat.first_error_valid;
			result_s2.run_complete       <= item_s1.last_byte;
		end
	end

	assign result_valid = valid_s2;
	assign result_item  = result_s2;

	// A run without a mismatch so far reports no errors and a zero offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_item.first_error_valid) |->
			(result_item.error_total == '0 && result_item.first_error_offset == '0))
		else $error("error totals present without a recorded first error");

	// A mismatching byte always leaves a non-zero error total and marks the run as erroneous.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_item.mismatch) |->
			(result_item.first_error_valid && result_item.error_total != '0))
		else $error("mismatch not reflected in run statistics");

	// A byte held in the input register is neither lost nor altered while it waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("waiting byte dropped or changed");

endmodule

FILE: sv/prbs_chk_gen.sv
module prbs_chk_gen
	import prbs_chk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              run_start,
	input  logic [MODE_W-1:0] mode,
	input  logic [CFG_W-1:0]  seed,
	output logic [BYTE_W-1:0] expected_byte
);

	logic [LFSR_W-1:0] shift_q;
	logic [LFSR_W-1:0] start_state;
	logic [LFSR_W-1:0] next_state;
	logic [BYTE_W-1:0] prbs_byte;
	logic              prbs_sel;

	// Eight shifts of the generator; each feedback bit becomes the next output bit,
	// least significant bit first.
	function automatic logic [LFSR_W+BYTE_W-1:0] step_byte(input logic [LFSR_W-1:0] s_in);
		logic [LFSR_W-1:0] s;
		logic [BYTE_W-1:0] b;
		logic              fb;
		s = s_in;
		b = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			fb = s[14] ^ s[13] ^ s[12] ^ s[10];
			s = {s[LFSR_W-2:0], fb};
			b[k] = fb;
		end
		return {s, b};
	endfunction

	assign start_state = run_start ? (seed | SEED_LSB) : shift_q;
	assign {next_state, prbs_byte} = step_byte(start_state);

	always_comb begin
		prbs_sel = 1'b0;
		case (mode)
			MODE_ZEROS: expected_byte = FILL_ZEROS;
			MODE_ONES:  expected_byte = FILL_ONES;
			MODE_55:    expected_byte = FILL_55;
			MODE_AA:    expected_byte = FILL_AA;
			default: begin
				expected_byte = prbs_byte;
				prbs_sel      = 1'b1;
			end
		endcase
	end

	// The generator is reloaded at every run start, even in a fill mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SEED_RESET;
		end else if (advance) begin
			shift_q <= prbs_sel ? next_state : start_state;
		end
	end

endmodule

FILE: sv/prbs_chk_stats.sv
module prbs_chk_stats
	import prbs_chk_pkg::*;
#(
	parameter int unsigned MAX_RUN_LENGTH = DEF_MAX_RUN_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  stats_ctl_t ctl,
	output stats_t     stat
);

	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(
		(MAX_RUN_LENGTH > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : MAX_RUN_LENGTH);
	localparam logic [POS_W-1:0] POS_MAX = '1;

	logic [POS_W-1:0]   pos_q;
	logic [COUNT_W-1:0] count_q;
	logic [POS_W-1:0]   offset_q;
	logic               seen_q;

	logic [COUNT_W-1:0] count_next;
	logic [POS_W-1:0]   offset_next;
	logic               seen_next;

	always_comb begin
		count_next  = (ctl.mismatch && (count_q < COUNT_LIMIT)) ? count_q + 1'b1 : count_q;
		offset_next = (ctl.mismatch && !seen_q) ? pos_q : offset_q;
		seen_next   = seen_q | ctl.mismatch;
	end

	assign stat.run_start          = (pos_q == '0);
	assign stat.error_total        = count_next;
	assign stat.first_error_offset = seen_next ? offset_next : '0;
	assign stat.first_error_valid  = seen_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			count_q  <= '0;
			offset_q <= '0;
			seen_q   <= 1'b0;
		end else if (ctl.advance) begin
			if (ctl.last_byte) begin
				pos_q    <= '0;
				count_q  <= '0;
				offset_q <= '0;
				seen_q   <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
				count_q  <= count_next;
				offset_q <= offset_next;
				seen_q   <= seen_next;
			end
		end
	end

endmodule

FILE: tb/sv/prbs_result_checker.sv
// Watches the configuration port and both channels of the pattern checker, keeps its own
// copy of the pattern generator and run statistics, and compares every result transfer
// with the oldest prediction still waiting.
module prbs_result_checker
	import prbs_chk_pkg::*;
#(
	parameter int unsigned MAX_RUN_LENGTH = DEF_MAX_RUN_LENGTH
) (
	input  logic             clk,
	input  logic             arst_n,

	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,

	input  logic             byte_valid,
	input  logic             byte_stall,
	input  byte_item_t       byte_item,

	input  logic             result_valid,
	input  logic             result_stall,
	input  result_item_t     result_item,

	output int               outstanding,
	output int               fail_count
);

	localparam int unsigned COUNT_CAP =
		(MAX_RUN_LENGTH < COUNT_FIELD_MAX) ? MAX_RUN_LENGTH : COUNT_FIELD_MAX;

	logic [MODE_W-1:0]  mode_reg;
	logic [LFSR_W-1:0]  seed_reg;
	logic [LFSR_W-1:0]  lfsr_state;
	logic [POS_W-1:0]   run_position;
	logic [POS_W-1:0]   first_miss_pos;
	logic [COUNT_W-1:0] miss_count;
	logic               miss_seen;

	result_item_t expected_q[$];
	result_item_t want;
	int           mismatch_total = 0;

	assign fail_count = mismatch_total;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want_val);
		mismatch_total++;
		$display("mismatch on %s: got 0x%0h, predicted 0x%0h (at %0t)",
			what, got, want_val, $realtime);
	endtask

	function automatic void clear_run();
		run_position = '0;
		miss_count = '0;
		first_miss_pos = '0;
		miss_seen = 1'b0;
	endfunction

	// Eight shifts of the LFSR; each feedback bit lands in the byte LSB first.
	function automatic logic [BYTE_W-1:0] prbs_advance();
		logic [BYTE_W-1:0] b;
		logic fb;
		b = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			fb = lfsr_state[14] ^ lfsr_state[13] ^ lfsr_state[12] ^ lfsr_state[10];
			lfsr_state = {lfsr_state[LFSR_W-2:0], fb};
			b[k] = fb;
		end
		return b;
	endfunction

	function automatic result_item_t predict_result(input byte_item_t item);
		result_item_t r;
		logic [BYTE_W-1:0] pattern;
		logic miss;
		if (run_position == '0)
			lfsr_state = seed_reg | SEED_LSB;
		case (mode_reg)
			MODE_ZEROS: pattern = FILL_ZEROS;
			MODE_ONES:  pattern = FILL_ONES;
			MODE_55:    pattern = FILL_55;
			MODE_AA:    pattern = FILL_AA;
			default:    pattern = prbs_advance();
		endcase
		miss = (item.received_byte != pattern);
		if (miss) begin
			if (!miss_seen) begin
				miss_seen = 1'b1;
				first_miss_pos = run_position;
			end
			if (miss_count < COUNT_CAP)
				miss_count++;
		end
		r.expected_byte = pattern;
		r.mismatch = miss;
		r.error_total = miss_count;
		r.first_error_offset = miss_seen ? first_miss_pos : '0;
		r.first_error_valid = miss_seen;
		r.run_complete = item.last_byte;
		if (run_position != '1)
			run_position++;
		if (item.last_byte)
			clear_run();
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_reg = MODE_PRBS;
			seed_reg = SEED_RESET;
			lfsr_state = SEED_RESET | SEED_LSB;
			clear_run();
			expected_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN_MODE: mode_reg = cfg_data[MODE_W-1:0];
					REG_PRBS_SEED:    seed_reg = cfg_data[LFSR_W-1:0];
				endcase
			end
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing pending", result_item, 0);
				end else begin
					want = expected_q.pop_front();
					if (result_item.expected_byte !== want.expected_byte)
						report_mismatch("expected_byte", result_item.expected_byte,
							want.expected_byte);
					if (result_item.mismatch !== want.mismatch)
						report_mismatch("mismatch", result_item.mismatch, want.mismatch);
					if (result_item.error_total !== want.error_total)
						report_mismatch("error_total", result_item.error_total,
							want.error_total);
					if (result_item.first_error_offset !== want.first_error_offset)
						report_mismatch("first_error_offset",
							result_item.first_error_offset, want.first_error_offset);
					if (result_item.first_error_valid !== want.first_error_valid)
						report_mismatch("first_error_valid",
							result_item.first_error_valid, want.first_error_valid);
					if (result_item.run_complete !== want.run_complete)
						report_mismatch("run_complete", result_item.run_complete,
							want.run_complete);
				end
			end
			if (byte_valid && !byte_stall)
				expected_q.push_back(predict_result(byte_item));
			outstanding <= expected_q.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// Top of the pattern checker bench. It drives reset, the configuration port and the byte
// channel, applies random back-pressure on the result channel, and gives the verdict.
// All prediction and comparison lives in the result checker instantiated beside the block.
module testbench;
	import prbs_chk_pkg::*;

	// The watchdog ends the run after this many cycles without any transfer.
	localparam int HANG_LIMIT = 2000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             byte_valid;
	logic             byte_stall;
	byte_item_t       byte_item;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_item_t     result_item;

	int outstanding;
	int fail_count;

	// When set, neither side inserts idle cycles.
	bit quiet = 1'b0;

	// Stimulus-side copy of the link pattern, so that most received bytes can be sent
	// correct and errors injected on purpose. It mirrors the registers as written here.
	logic [MODE_W-1:0] link_mode = MODE_PRBS;
	logic [LFSR_W-1:0] link_seed = SEED_RESET;
	logic [LFSR_W-1:0] link_lfsr = SEED_RESET;
	bit                run_fresh = 1'b1;

	int stall_left = 0;
	int free_left = 0;

	prbs_pattern_checker #(
		.MAX_RUN_LENGTH(DEF_MAX_RUN_LENGTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

	prbs_result_checker #(
		.MAX_RUN_LENGTH(DEF_MAX_RUN_LENGTH)
	) result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle length for either side: mostly none, often a few cycles, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Result back-pressure: stall bursts separated by free stretches, some of which are long
	// enough to let the pipeline run flat out.
	always @(posedge clk) begin
		if (quiet) begin
			stall_left = 0;
			free_left = 0;
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (free_left > 0) begin
			free_left--;
			result_stall <= 1'b0;
		end else begin
			free_left = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150)
				: $urandom_range(0, 6);
			stall_left = pick_gap();
			result_stall <= 1'b0;
		end
	end

	// Next byte of the pattern the far end would send. The LFSR is reloaded from the seed
	// only at the first byte of a run, and fixed fills leave it untouched, as in the block.
	function automatic logic [BYTE_W-1:0] link_byte();
		logic [BYTE_W-1:0] b;
		logic fb;
		b = '0;
		if (run_fresh)
			link_lfsr = link_seed | SEED_LSB;
		run_fresh = 1'b0;
		case (link_mode)
			MODE_ZEROS: b = FILL_ZEROS;
			MODE_ONES:  b = FILL_ONES;
			MODE_55:    b = FILL_55;
			MODE_AA:    b = FILL_AA;
			default: begin
				for (int k = 0; k < BYTE_W; k++) begin
					fb = link_lfsr[14] ^ link_lfsr[13] ^ link_lfsr[12] ^ link_lfsr[10];
					link_lfsr = {link_lfsr[LFSR_W-2:0], fb};
					b[k] = fb;
				end
			end
		endcase
		return b;
	endfunction

	// Drop the byte valid and hold off until every predicted result has been taken. The
	// first wait covers a transfer made at the current edge, whose count is not yet visible.
	task automatic wait_drained();
		byte_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Register writes are only issued with the block drained. The enable is high for a single
	// cycle and is low again before the task returns, so back-to-back writes never stack assignments.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PATTERN_MODE)
			link_mode = data[MODE_W-1:0];
		else
			link_seed = data[LFSR_W-1:0];
		@(posedge clk);
	endtask

	// One byte transfer. After it the sender either keeps valid up for the next byte,
	// idles for a while, or occasionally pauses until the block has fully drained.
	task automatic send_byte(input logic [BYTE_W-1:0] rx, input logic last);
		byte_item_t item;
		int gap;
		item.received_byte = rx;
		item.last_byte = last;
		byte_valid <= 1'b1;
		byte_item <= item;
		do @(posedge clk); while (byte_stall);
		if (last)
			run_fresh = 1'b1;
		gap = pick_gap();
		if (!quiet && $urandom_range(0, 99) < 2) begin
			wait_drained();
		end else if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Watchdog: a hang on either channel, or results that never arrive, ends the run.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (byte_valid && !byte_stall)
					|| (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [BYTE_W-1:0] link_val;
		logic [LFSR_W-1:0] seed_val;
		int roll;

		cfg_we = 1'b0;
		cfg_index = REG_PATTERN_MODE;
		cfg_data = '0;
		byte_valid = 1'b0;
		byte_item = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: PRBS with seed one. A match at offset zero, then two errors, so the
		// first error offset is one and the total reaches two at the end of the run.
		send_byte(link_byte(), 1'b0);
		send_byte(link_byte() ^ 8'h80, 1'b0);
		send_byte(~link_byte(), 1'b1);

		// Each fixed fill, with matches, mismatches against the complement and the fill
		// values at the extremes of the byte.
		wait_drained();
		write_reg(REG_PATTERN_MODE, CFG_W'(MODE_ZEROS));
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_drained();
		write_reg(REG_PATTERN_MODE, CFG_W'(MODE_ONES));
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_drained();
		write_reg(REG_PATTERN_MODE, CFG_W'(MODE_55));
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		wait_drained();
		write_reg(REG_PATTERN_MODE, CFG_W'(MODE_AA));
		// Single-byte runs: one clean, one failing at offset zero.
		send_byte(8'hAA, 1'b1);
		send_byte(8'h55, 1'b1);

		// An undefined mode code behaves as PRBS. A zero seed gets its low bit forced.
		wait_drained();
		write_reg(REG_PRBS_SEED, '0);
		write_reg(REG_PATTERN_MODE, CFG_W'(3'd7));
		send_byte(link_byte(), 1'b0);
		send_byte(link_byte(), 1'b0);
		// A seed written in the middle of a run must not disturb that run.
		wait_drained();
		write_reg(REG_PRBS_SEED, '1);
		send_byte(link_byte(), 1'b1);
		send_byte(link_byte(), 1'b0);
		send_byte(~link_byte(), 1'b1);

		// Switching to a fixed fill mid-run leaves the LFSR where it was; going back to a
		// PRBS code picks the sequence up from that point.
		wait_drained();
		write_reg(REG_PATTERN_MODE, CFG_W'(3'd5));
		write_reg(REG_PRBS_SEED, 15'h4000);
		send_byte(link_byte() ^ 8'h01, 1'b0);
		send_byte(link_byte(), 1'b0);
		wait_drained();
		write_reg(REG_PATTERN_MODE, CFG_W'(MODE_ZEROS));
		send_byte(link_byte(), 1'b0);
		wait_drained();
		write_reg(REG_PATTERN_MODE, CFG_W'(3'd6));
		send_byte(link_byte(), 1'b1);
		wait_drained();
		write_reg(REG_PATTERN_MODE, CFG_W'(MODE_PRBS));
		send_byte(link_byte(), 1'b1);

		// Random part: segments under different settings. Most bytes follow the pattern,
		// some carry a single flipped bit and some are plain noise. Runs end at random, so
		// settings often change in the middle of a run.
		for (int seg = 0; seg < 8; seg++) begin
			wait_drained();
			quiet = (seg == 5);
			if ($urandom_range(0, 3) != 0) begin
				write_reg(REG_PATTERN_MODE, ($urandom_range(0, 1) != 0) ? CFG_W'(MODE_PRBS)
					: CFG_W'($urandom_range(0, 7)));
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 4))
					0:       seed_val = '0;
					1:       seed_val = SEED_RESET;
					2:       seed_val = '1;
					3:       seed_val = 15'h4000;
					default: seed_val = LFSR_W'($urandom);
				endcase
				write_reg(REG_PRBS_SEED, seed_val);
			end
			for (int i = 0; i < 85; i++) begin
				link_val = link_byte();
				roll = $urandom_range(0, 99);
				if (roll < 8)
					link_val = BYTE_W'($urandom_range(0, 255));
				else if (roll < 16)
					link_val = link_val ^ BYTE_W'(1 << $urandom_range(0, 7));
				send_byte(link_val, $urandom_range(0, 99) < 7);
			end
		end
		send_byte(link_byte(), 1'b1);

		// A short PRBS run at the end with one error in the middle.
		wait_drained();
		quiet = 1'b0;
		write_reg(REG_PATTERN_MODE, CFG_W'(MODE_PRBS));
		for (int i = 0; i < 6; i++)
			send_byte((i == 3) ? ~link_byte() : link_byte(), i == 5);

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
sv/prbs_chk_pkg.sv
sv/prbs_chk_gen.sv
sv/prbs_chk_stats.sv
sv/prbs_pattern_checker.sv
tb/sv/prbs_result_checker.sv
tb/sv/testbench.sv
